// File: rtl/core/ecwp_pkg.sv
// shared types, constants and register codes of the event centroid wobble predictor
package ecwp_pkg;

    // fixed sizes
    localparam int EVENTS_PER_BATCH = 4;
    localparam int COORD_W          = 7;
    localparam int SUM_W            = 9;
    localparam int CFG_INDEX_W      = 3;
    localparam int CFG_DATA_W       = 8;
    localparam int IN_DATA_W        = 32 * EVENTS_PER_BATCH;
    localparam int OUT_DATA_W       = 32;

    // event word layout
    localparam int X_LSB = 24;
    localparam int Y_LSB = 17;

    // limits
    localparam logic [6:0] PERIOD_CAP = 7'd127;
    localparam logic [7:0] STREAK_MAX = 8'd255;

    // register reset values
    localparam logic [7:0] RST_CRITICAL_AMPLITUDE    = 8'd80;
    localparam logic [7:0] RST_FLOOR_AMPLITUDE       = 8'd4;
    localparam logic [7:0] RST_GROWTH_WINDOWS_NEEDED = 8'd2;
    localparam logic [7:0] RST_CROSSINGS_NEEDED      = 8'd3;
    localparam logic [5:0] RST_COUNTDOWN_LIMIT       = 6'd63;
    localparam logic [2:0] RST_SMOOTHING_SHIFT       = 3'd3;
    localparam logic [7:0] RST_EXTENT_WINDOW_BATCHES = 8'd32;
    localparam logic [7:0] RST_PERIOD_WINDOW_BATCHES = 8'd64;

    // register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CRITICAL_AMPLITUDE    = 3'd0,
        REG_FLOOR_AMPLITUDE       = 3'd1,
        REG_GROWTH_WINDOWS_NEEDED = 3'd2,
        REG_CROSSINGS_NEEDED      = 3'd3,
        REG_COUNTDOWN_LIMIT       = 3'd4,
        REG_SMOOTHING_SHIFT       = 3'd5,
        REG_EXTENT_WINDOW_BATCHES = 3'd6,
        REG_PERIOD_WINDOW_BATCHES = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0] critical_amplitude;
        logic [7:0] floor_amplitude;
        logic [7:0] growth_windows_needed;
        logic [7:0] crossings_needed;
        logic [5:0] countdown_limit;
        logic [2:0] smoothing_shift;
        logic [7:0] extent_window_batches;
        logic [7:0] period_window_batches;
    } cfg_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_UPDATE,
        ST_COUNT,
        ST_WRITE
    } state_t;

    // sequencer to datapath
    typedef struct packed {
        logic load;
        logic sum_step;
        logic update;
        logic count_step;
        logic count_done;
        logic out_load;
    } ctrl_t;

    // datapath to sequencer
    typedef struct packed {
        logic need_count;
        logic loop_go;
    } stat_t;

    // shared adder / compare unit
    typedef struct packed {
        logic [SUM_W-1:0] a0;
        logic [SUM_W-1:0] b0;
        logic [SUM_W-1:0] a1;
        logic [SUM_W-1:0] b1;
        logic [SUM_W-1:0] c;
    } alu_in_t;

    typedef struct packed {
        logic [SUM_W-1:0] sum0;
        logic [SUM_W-1:0] sum1;
        logic             lt;
    } alu_out_t;

    // one result word
    typedef struct packed {
        logic [5:0] countdown;
        logic [7:0] amplitude;
        logic [6:0] period;
        logic       valid_res;
        logic [3:0] sequence_res;
    } result_t;

endpackage

// File: rtl/core/ecwp_alu.sv
// shared two-lane adder with compare, used for event sums and the countdown loop
module ecwp_alu
(
    input  ecwp_pkg::alu_in_t  op,
    output ecwp_pkg::alu_out_t res
);

    // lane 0 carries x sum or accumulator, lane 1 y sum or step count
    always_comb
    begin
        res.sum0 = op.a0 + op.b0;
        res.sum1 = op.a1 + op.b1;
        res.lt   = (op.a0 < op.c);
    end

endmodule

// File: rtl/core/ecwp_seq.sv
// sequencer: event summing, window update, countdown loop, result hand-off
module ecwp_seq
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                out_free,
    input  ecwp_pkg::stat_t     stat,
    output logic                in_ready,
    output ecwp_pkg::ctrl_t     ctrl
);

    ecwp_pkg::state_t state_reg;
    ecwp_pkg::state_t state_next;
    logic [1:0]       sum_cnt_reg;
    logic [1:0]       sum_cnt_next;

    // state and event counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ecwp_pkg::ST_IDLE;
            sum_cnt_reg <= 2'd0;
        end
        else
        begin
            state_reg   <= state_next;
            sum_cnt_reg <= sum_cnt_next;
        end
    end

    // next state and control
    always_comb
    begin
        state_next   = state_reg;
        sum_cnt_next = sum_cnt_reg;
        in_ready     = 1'b0;
        ctrl         = '0;
        case (state_reg)
            ecwp_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.load    = 1'b1;
                    sum_cnt_next = 2'd0;
                    state_next   = ecwp_pkg::ST_SUM;
                end
            end
            ecwp_pkg::ST_SUM:
            begin
                ctrl.sum_step = 1'b1;
                sum_cnt_next  = sum_cnt_reg + 2'd1;
                if (sum_cnt_reg == 2'(ecwp_pkg::EVENTS_PER_BATCH - 1))
                begin
                    state_next = ecwp_pkg::ST_UPDATE;
                end
            end
            ecwp_pkg::ST_UPDATE:
            begin
                ctrl.update = 1'b1;
                state_next  = stat.need_count ? ecwp_pkg::ST_COUNT : ecwp_pkg::ST_WRITE;
            end
            ecwp_pkg::ST_COUNT:
            begin
                if (stat.loop_go)
                begin
                    ctrl.count_step = 1'b1;
                end
                else
                begin
                    ctrl.count_done = 1'b1;
                    state_next      = ecwp_pkg::ST_WRITE;
                end
            end
            ecwp_pkg::ST_WRITE:
            begin
                if (out_free)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = ecwp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ecwp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/ecwp_track.sv
// tracking datapath: centroid, smoothing, crossings, extent windows, countdown
module ecwp_track
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  ecwp_pkg::ctrl_t                        ctrl,
    input  ecwp_pkg::cfg_t                         cfg,
    input  logic [ecwp_pkg::IN_DATA_W-1:0]         words,
    input  ecwp_pkg::alu_out_t                     alu_res,
    output ecwp_pkg::alu_in_t                      alu_op,
    output ecwp_pkg::stat_t                        stat,
    output ecwp_pkg::result_t                      result
);

    localparam int N = ecwp_pkg::EVENTS_PER_BATCH;
    localparam int CW = ecwp_pkg::COORD_W;

    // batch under work
    logic [CW-1:0]               ev_x_reg [N];
    logic [CW-1:0]               ev_y_reg [N];
    logic [ecwp_pkg::SUM_W-1:0]  sx_reg;
    logic [ecwp_pkg::SUM_W-1:0]  sy_reg;

    // countdown loop
    logic [ecwp_pkg::SUM_W-1:0]  acc_reg;
    logic [7:0]                  growth_reg;
    logic [5:0]                  cd_reg;

    // tracking state
    logic [7:0]    smooth_x_reg;
    logic          previous_sign_reg;
    logic          sign_seen_reg;
    logic [7:0]    crossings_in_window_reg;
    logic [7:0]    period_window_count_reg;
    logic [3:0]    last_crossing_seq_reg;
    logic [1:0]    crossings_total_reg;
    logic          period_ok_reg;
    logic [6:0]    period_estimate_reg;
    logic [7:0]    extent_window_count_reg;
    logic [CW-1:0] min_x_reg;
    logic [CW-1:0] max_x_reg;
    logic [CW-1:0] min_y_reg;
    logic [CW-1:0] max_y_reg;
    logic          extent_started_reg;
    logic [7:0]    previous_amplitude_reg;
    logic          previous_amplitude_seen_reg;
    logic [7:0]    growth_streak_reg;
    logic [3:0]    batch_seq_reg;
    logic [5:0]    held_countdown_reg;
    logic [7:0]    held_amplitude_reg;
    logic [6:0]    held_period_reg;
    logic          held_valid_reg;

    // update cycle values
    logic [CW-1:0] cx;
    logic [CW-1:0] cy;
    logic [7:0]    smooth_x_next;
    logic          sign;
    logic          crossing;
    logic [7:0]    crossings_in_window_next;
    logic [1:0]    crossings_total_next;
    logic [3:0]    half;
    logic [6:0]    period_estimate_next;
    logic          period_ok_next;
    logic [3:0]    last_crossing_seq_next;
    logic [CW-1:0] min_x_next;
    logic [CW-1:0] max_x_next;
    logic [CW-1:0] min_y_next;
    logic [CW-1:0] max_y_next;
    logic          extent_started_next;
    logic [8:0]    pw_inc;
    logic          period_close;
    logic [7:0]    period_window_count_next;
    logic [8:0]    ew_inc;
    logic          extent_close;
    logic [7:0]    extent_window_count_next;
    logic [7:0]    amp;
    logic [7:0]    growth;
    logic [7:0]    growth_streak_mid;
    logic [7:0]    growth_streak_next;
    logic [7:0]    previous_amplitude_next;
    logic          previous_amplitude_seen_next;
    logic          predict;

    // operand select for the shared unit
    always_comb
    begin
        alu_op.c = {1'b0, cfg.critical_amplitude};
        if (ctrl.sum_step)
        begin
            alu_op.a0 = sx_reg;
            alu_op.b0 = {2'b00, ev_x_reg[0]};
            alu_op.a1 = sy_reg;
            alu_op.b1 = {2'b00, ev_y_reg[0]};
        end
        else
        begin
            alu_op.a0 = acc_reg;
            alu_op.b0 = {1'b0, growth_reg};
            alu_op.a1 = {3'b000, cd_reg};
            alu_op.b1 = 9'd1;
        end
    end

    // per-batch update
    always_comb
    begin
        // loop keeps going below target and under the cap
        stat.loop_go = alu_res.lt && (cd_reg < cfg.countdown_limit);

        cx = sx_reg[ecwp_pkg::SUM_W-1:2];
        cy = sy_reg[ecwp_pkg::SUM_W-1:2];

        // leaky integrator and crossing detect
        smooth_x_next = 8'(({1'b0, smooth_x_reg} - {1'b0, smooth_x_reg >> cfg.smoothing_shift})
                           + {2'b00, cx >> cfg.smoothing_shift});
        sign     = ({1'b0, cx} < smooth_x_next);
        crossing = sign_seen_reg && (sign != previous_sign_reg);

        crossings_in_window_next = crossings_in_window_reg;
        crossings_total_next     = crossings_total_reg;
        period_estimate_next     = period_estimate_reg;
        period_ok_next           = period_ok_reg;
        last_crossing_seq_next   = last_crossing_seq_reg;
        half                     = batch_seq_reg - last_crossing_seq_reg;
        if (!sign_seen_reg)
        begin
            last_crossing_seq_next = batch_seq_reg;
        end
        else if (crossing)
        begin
            crossings_in_window_next = crossings_in_window_reg + 8'd1;
            last_crossing_seq_next   = batch_seq_reg;
            if (crossings_total_reg < 2'd2)
            begin
                crossings_total_next = crossings_total_reg + 2'd1;
            end
            if (crossings_total_next == 2'd2)
            begin
                // a wrapped sequence distance is huge, so the period caps
                period_estimate_next = (batch_seq_reg >= last_crossing_seq_reg) ?
                                       {2'b00, half, 1'b0} : ecwp_pkg::PERIOD_CAP;
                period_ok_next = 1'b1;
            end
        end

        // extent bounds including this centroid
        if (!extent_started_reg)
        begin
            min_x_next = cx;
            max_x_next = cx;
            min_y_next = cy;
            max_y_next = cy;
        end
        else
        begin
            min_x_next = (cx < min_x_reg) ? cx : min_x_reg;
            max_x_next = (cx > max_x_reg) ? cx : max_x_reg;
            min_y_next = (cy < min_y_reg) ? cy : min_y_reg;
            max_y_next = (cy > max_y_reg) ? cy : max_y_reg;
        end
        extent_started_next = 1'b1;

        // period window
        pw_inc       = {1'b0, period_window_count_reg} + 9'd1;
        period_close = (pw_inc >= {1'b0, cfg.period_window_batches});
        period_window_count_next = pw_inc[7:0];
        growth_streak_mid        = growth_streak_reg;
        if (period_close)
        begin
            period_window_count_next = 8'd0;
            if (crossings_in_window_next < cfg.crossings_needed)
            begin
                period_ok_next    = 1'b0;
                growth_streak_mid = 8'd0;
            end
            crossings_in_window_next = 8'd0;
        end

        // extent window
        ew_inc       = {1'b0, extent_window_count_reg} + 9'd1;
        extent_close = (ew_inc >= {1'b0, cfg.extent_window_batches});
        extent_window_count_next = ew_inc[7:0];
        amp = {1'b0, max_x_next - min_x_next} + {1'b0, max_y_next - min_y_next};
        growth                       = 8'd0;
        growth_streak_next           = growth_streak_mid;
        previous_amplitude_next      = previous_amplitude_reg;
        previous_amplitude_seen_next = previous_amplitude_seen_reg;
        if (extent_close)
        begin
            extent_window_count_next = 8'd0;
            extent_started_next      = 1'b0;
            if (previous_amplitude_seen_reg)
            begin
                if (amp > previous_amplitude_reg)
                begin
                    growth = amp - previous_amplitude_reg;
                    if (growth_streak_mid != ecwp_pkg::STREAK_MAX)
                    begin
                        growth_streak_next = growth_streak_mid + 8'd1;
                    end
                end
                else
                begin
                    growth_streak_next = 8'd0;
                end
            end
            previous_amplitude_next      = amp;
            previous_amplitude_seen_next = 1'b1;
        end

        // growing oscillation below the critical amplitude
        predict = period_ok_next && (growth_streak_next >= cfg.growth_windows_needed) &&
                  (amp >= cfg.floor_amplitude) && (amp < cfg.critical_amplitude) &&
                  (growth != 8'd0);
        stat.need_count = extent_close && predict;
    end

    // batch load and event summing
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            sx_reg <= '0;
            sy_reg <= '0;
            for (int i = 0; i < N; i++)
            begin
                ev_x_reg[i] <= words[32*i + ecwp_pkg::X_LSB +: CW];
                ev_y_reg[i] <= words[32*i + ecwp_pkg::Y_LSB +: CW];
            end
        end
        else if (ctrl.sum_step)
        begin
            sx_reg <= alu_res.sum0;
            sy_reg <= alu_res.sum1;
            for (int i = 0; i < N - 1; i++)
            begin
                ev_x_reg[i] <= ev_x_reg[i+1];
                ev_y_reg[i] <= ev_y_reg[i+1];
            end
        end
    end

    // countdown accumulator
    always_ff @(posedge clk)
    begin
        if (ctrl.update)
        begin
            acc_reg    <= {1'b0, amp};
            growth_reg <= growth;
            cd_reg     <= 6'd0;
        end
        else if (ctrl.count_step)
        begin
            acc_reg <= alu_res.sum0;
            cd_reg  <= alu_res.sum1[5:0];
        end
    end

    // tracking state and held results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_x_reg                <= '0;
            previous_sign_reg           <= 1'b0;
            sign_seen_reg               <= 1'b0;
            crossings_in_window_reg     <= '0;
            period_window_count_reg     <= '0;
            last_crossing_seq_reg       <= '0;
            crossings_total_reg         <= '0;
            period_ok_reg               <= 1'b0;
            period_estimate_reg         <= '0;
            extent_window_count_reg     <= '0;
            min_x_reg                   <= '0;
            max_x_reg                   <= '0;
            min_y_reg                   <= '0;
            max_y_reg                   <= '0;
            extent_started_reg          <= 1'b0;
            previous_amplitude_reg      <= '0;
            previous_amplitude_seen_reg <= 1'b0;
            growth_streak_reg           <= '0;
            batch_seq_reg               <= '0;
            held_countdown_reg          <= '0;
            held_amplitude_reg          <= '0;
            held_period_reg             <= '0;
            held_valid_reg              <= 1'b0;
        end
        else if (ctrl.update)
        begin
            smooth_x_reg                <= smooth_x_next;
            previous_sign_reg           <= sign;
            sign_seen_reg               <= 1'b1;
            crossings_in_window_reg     <= crossings_in_window_next;
            period_window_count_reg     <= period_window_count_next;
            last_crossing_seq_reg       <= last_crossing_seq_next;
            crossings_total_reg         <= crossings_total_next;
            period_ok_reg               <= period_ok_next;
            period_estimate_reg         <= period_estimate_next;
            extent_window_count_reg     <= extent_window_count_next;
            min_x_reg                   <= min_x_next;
            max_x_reg                   <= max_x_next;
            min_y_reg                   <= min_y_next;
            max_y_reg                   <= max_y_next;
            extent_started_reg          <= extent_started_next;
            previous_amplitude_reg      <= previous_amplitude_next;
            previous_amplitude_seen_reg <= previous_amplitude_seen_next;
            growth_streak_reg           <= growth_streak_next;
            batch_seq_reg               <= batch_seq_reg + 4'd1;
            if (extent_close)
            begin
                held_amplitude_reg <= amp;
                held_period_reg    <= period_estimate_next;
                held_valid_reg     <= predict;
                held_countdown_reg <= 6'd0;
            end
        end
        else if (ctrl.count_done)
        begin
            held_countdown_reg <= cd_reg;
        end
    end

    // current status word
    always_comb
    begin
        result.countdown    = held_countdown_reg;
        result.amplitude    = held_amplitude_reg;
        result.period       = held_period_reg;
        result.valid_res    = held_valid_reg;
        result.sequence_res = batch_seq_reg;
    end

endmodule

// File: rtl/core/event_centroid_wobble_predictor.sv
// top level of the event centroid wobble predictor: ports, config, output register
//
//  channel  | signals                        | word
//  ---------+--------------------------------+------------------------------------
//  s        | s_tvalid s_tready s_tdata[128] | batch of four event words
//  m        | m_tvalid m_tready m_tdata[32]  | status: countdown, amplitude, period
//  cfg      | cfg_we cfg_index cfg_data      | register write, no read-back
//
// a batch passes the accept state, a sum step per event through the shared adder, the
// update state and the write state into the output register, which waits while that
// register is not free; at an extent window end with a prediction the countdown loop
// runs between update and write, one addition per cycle
// async active-low reset restores register defaults and clears all tracking state
// a result waits in the output register; the next batch is taken meanwhile and
// its result is held back until that register is free
module event_centroid_wobble_predictor
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // event batch in
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // event_word_a, event_word_b, event_word_c, event_word_d
    input  logic [ecwp_pkg::IN_DATA_W-1:0]        s_tdata,
    // status out
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // countdown, amplitude, period, valid_res, sequence_res, zero fill
    output logic [ecwp_pkg::OUT_DATA_W-1:0]       m_tdata,
    // register writes
    input  logic                                  cfg_we,
    input  logic [ecwp_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [ecwp_pkg::CFG_DATA_W-1:0]       cfg_data
);

    ecwp_pkg::cfg_t     cfg_reg;
    ecwp_pkg::ctrl_t    ctrl;
    ecwp_pkg::stat_t    stat;
    ecwp_pkg::alu_in_t  alu_op;
    ecwp_pkg::alu_out_t alu_res;
    ecwp_pkg::result_t  result;
    logic               out_free;
    logic               m_tvalid_reg;
    logic [ecwp_pkg::OUT_DATA_W-1:0] m_tdata_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.critical_amplitude    <= ecwp_pkg::RST_CRITICAL_AMPLITUDE;
            cfg_reg.floor_amplitude       <= ecwp_pkg::RST_FLOOR_AMPLITUDE;
            cfg_reg.growth_windows_needed <= ecwp_pkg::RST_GROWTH_WINDOWS_NEEDED;
            cfg_reg.crossings_needed      <= ecwp_pkg::RST_CROSSINGS_NEEDED;
            cfg_reg.countdown_limit       <= ecwp_pkg::RST_COUNTDOWN_LIMIT;
            cfg_reg.smoothing_shift       <= ecwp_pkg::RST_SMOOTHING_SHIFT;
            cfg_reg.extent_window_batches <= ecwp_pkg::RST_EXTENT_WINDOW_BATCHES;
            cfg_reg.period_window_batches <= ecwp_pkg::RST_PERIOD_WINDOW_BATCHES;
        end
        else if (cfg_we)
        begin
            case (ecwp_pkg::cfg_idx_t'(cfg_index))
                ecwp_pkg::REG_CRITICAL_AMPLITUDE:    cfg_reg.critical_amplitude    <= cfg_data;
                ecwp_pkg::REG_FLOOR_AMPLITUDE:       cfg_reg.floor_amplitude       <= cfg_data;
                ecwp_pkg::REG_GROWTH_WINDOWS_NEEDED: cfg_reg.growth_windows_needed <= cfg_data;
                ecwp_pkg::REG_CROSSINGS_NEEDED:      cfg_reg.crossings_needed      <= cfg_data;
                ecwp_pkg::REG_COUNTDOWN_LIMIT:       cfg_reg.countdown_limit       <= cfg_data[5:0];
                ecwp_pkg::REG_SMOOTHING_SHIFT:       cfg_reg.smoothing_shift       <= cfg_data[2:0];
                ecwp_pkg::REG_EXTENT_WINDOW_BATCHES: cfg_reg.extent_window_batches <= cfg_data;
                ecwp_pkg::REG_PERIOD_WINDOW_BATCHES: cfg_reg.period_window_batches <= cfg_data;
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    // sequencer
    ecwp_seq u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .out_free (out_free),
        .stat     (stat),
        .in_ready (s_tready),
        .ctrl     (ctrl)
    );

    // shared arithmetic unit
    ecwp_alu u_alu
    (
        .op  (alu_op),
        .res (alu_res)
    );

    // tracking datapath
    ecwp_track u_track
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .cfg     (cfg_reg),
        .words   (s_tdata),
        .alu_res (alu_res),
        .alu_op  (alu_op),
        .stat    (stat),
        .result  (result)
    );

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (ctrl.out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // output register word
    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            m_tdata_reg <= {6'd0, result.sequence_res, result.valid_res, result.period,
                            result.amplitude, result.countdown};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // a batch is never taken back to back
    a_one_in_flight : assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("batch accepted while another is in work");

    // a new result only lands in a free output register
    a_out_load_free : assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("output register overwritten while stalled");

    // a countdown is only reported with a valid prediction
    a_countdown_valid : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[21] || (m_tdata[5:0] == 6'd0)))
        else $error("countdown without valid prediction");

endmodule

// File: sim/event_centroid_wobble_predictor_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the event centroid wobble predictor
module event_centroid_wobble_predictor_tb;

    import ecwp_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int RANDOM_BATCHES  = 1650;
    localparam int PHASE_BATCHES   = 150;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 100;
    localparam int IDLE_PCT        = 21;
    localparam int PRINT_CAP       = 100;

    // tracking state of the wobble predictor, one copy of each tracking register of the block
    typedef struct {
        logic [7:0] smooth_x;
        logic       below;
        logic       below_seen;
        logic [7:0] window_crossings;
        logic [7:0] period_count;
        logic [3:0] last_crossing_seq;
        logic [1:0] crossings_seen;
        logic       period_ok;
        logic [6:0] period_est;
        logic [7:0] extent_count;
        logic [6:0] lo_x;
        logic [6:0] hi_x;
        logic [6:0] lo_y;
        logic [6:0] hi_y;
        logic       extent_open;
        logic [7:0] last_amp;
        logic       last_amp_seen;
        logic [7:0] growth_streak;
        logic [3:0] seq;
        result_t    held;
    } wobble_state_t;

    // one row of the directed part: a register write or a batch
    typedef struct {
        bit                     is_write;
        cfg_idx_t               idx;
        logic [7:0]             value;
        logic [IN_DATA_W-1:0]   batch;
        bit                     typed;
        result_t                want;
    } stim_row_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    cfg_t          settings;
    wobble_state_t wob;
    result_t       pending_status[$];

    bit steady          = 1'b0;
    int holds_asked     = 0;
    int mismatches      = 0;
    int results_checked = 0;
    int batches_sent    = 0;
    int windows_closed  = 0;
    int predictions     = 0;
    int cycles          = 0;

    event_centroid_wobble_predictor i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // register write as seen by the predictor
    function automatic void apply_setting(input cfg_idx_t idx, input logic [7:0] value);
        case (idx)
            REG_CRITICAL_AMPLITUDE:    settings.critical_amplitude    = value;
            REG_FLOOR_AMPLITUDE:       settings.floor_amplitude       = value;
            REG_GROWTH_WINDOWS_NEEDED: settings.growth_windows_needed = value;
            REG_CROSSINGS_NEEDED:      settings.crossings_needed      = value;
            REG_COUNTDOWN_LIMIT:       settings.countdown_limit       = value[5:0];
            REG_SMOOTHING_SHIFT:       settings.smoothing_shift       = value[2:0];
            REG_EXTENT_WINDOW_BATCHES: settings.extent_window_batches = value;
            REG_PERIOD_WINDOW_BATCHES: settings.period_window_batches = value;
            default: ;
        endcase
    endfunction

    // status word that one batch produces; advances the tracking state
    function automatic result_t predict_status(input logic [IN_DATA_W-1:0] batch);
        int unsigned sum_x;
        int unsigned sum_y;
        int unsigned cx;
        int unsigned cy;
        int unsigned sm;
        int unsigned sh;
        int unsigned half;
        int unsigned per;
        int unsigned cnt;
        int unsigned amp;
        int unsigned growth;
        int unsigned acc;
        int unsigned steps;
        logic [31:0] w;
        logic        below;
        logic        predicted;
        result_t     r;
        sum_x = 0;
        sum_y = 0;
        for (int i = 0; i < EVENTS_PER_BATCH; i++)
        begin
            w = batch[32*i +: 32];
            sum_x += w[X_LSB +: COORD_W];
            sum_y += w[Y_LSB +: COORD_W];
        end
        cx = sum_x >> 2;
        cy = sum_y >> 2;

        // leaky integrator on centroid x
        sh = settings.smoothing_shift;
        sm = wob.smooth_x;
        sm = (sm - (sm >> sh) + (cx >> sh)) & 32'hFF;
        wob.smooth_x = sm[7:0];
        below = (cx < sm);

        // crossings and period, distance taken as 32-bit unsigned
        if (wob.below_seen)
        begin
            if (below != wob.below)
            begin
                half = 32'(wob.seq) - 32'(wob.last_crossing_seq);
                wob.window_crossings = wob.window_crossings + 8'd1;
                wob.last_crossing_seq = wob.seq;
                if (wob.crossings_seen < 2'd2)
                    wob.crossings_seen = wob.crossings_seen + 2'd1;
                if (wob.crossings_seen >= 2'd2)
                begin
                    per = half << 1;
                    if (per > 32'(PERIOD_CAP))
                        per = 32'(PERIOD_CAP);
                    wob.period_est = per[6:0];
                    wob.period_ok = 1'b1;
                end
            end
        end
        else
            wob.last_crossing_seq = wob.seq;
        wob.below = below;
        wob.below_seen = 1'b1;

        // bounding box of the centroid
        if (!wob.extent_open)
        begin
            wob.lo_x = cx[6:0];
            wob.hi_x = cx[6:0];
            wob.lo_y = cy[6:0];
            wob.hi_y = cy[6:0];
            wob.extent_open = 1'b1;
        end
        else
        begin
            if (cx < 32'(wob.lo_x)) wob.lo_x = cx[6:0];
            if (cx > 32'(wob.hi_x)) wob.hi_x = cx[6:0];
            if (cy < 32'(wob.lo_y)) wob.lo_y = cy[6:0];
            if (cy > 32'(wob.hi_y)) wob.hi_y = cy[6:0];
        end

        // crossing validity window
        cnt = 32'(wob.period_count) + 1;
        if (cnt >= 32'(settings.period_window_batches))
        begin
            cnt = 0;
            if (wob.window_crossings < settings.crossings_needed)
            begin
                wob.period_ok = 1'b0;
                wob.growth_streak = '0;
            end
            wob.window_crossings = '0;
        end
        wob.period_count = cnt[7:0];

        // extent window end: amplitude, growth, countdown
        cnt = 32'(wob.extent_count) + 1;
        if (cnt >= 32'(settings.extent_window_batches))
        begin
            cnt = 0;
            windows_closed++;
            amp = (32'(wob.hi_x) - 32'(wob.lo_x)) + (32'(wob.hi_y) - 32'(wob.lo_y));
            if (amp > 255)
                amp = 255;
            growth = 0;
            predicted = 1'b0;
            steps = 0;
            wob.extent_open = 1'b0;
            if (wob.last_amp_seen)
            begin
                if (amp > 32'(wob.last_amp))
                begin
                    growth = amp - 32'(wob.last_amp);
                    if (wob.growth_streak < STREAK_MAX)
                        wob.growth_streak = wob.growth_streak + 8'd1;
                end
                else
                    wob.growth_streak = '0;
            end
            wob.last_amp = amp[7:0];
            wob.last_amp_seen = 1'b1;
            if (wob.period_ok && wob.growth_streak >= settings.growth_windows_needed &&
                amp >= 32'(settings.floor_amplitude) &&
                amp < 32'(settings.critical_amplitude) && growth > 0)
            begin
                predicted = 1'b1;
                predictions++;
                acc = amp;
                while (acc < 32'(settings.critical_amplitude) &&
                       steps < 32'(settings.countdown_limit))
                begin
                    acc += growth;
                    steps++;
                end
                if (acc < 32'(settings.critical_amplitude))
                    steps = settings.countdown_limit;
            end
            wob.held.amplitude = amp[7:0];
            wob.held.period = wob.period_est;
            wob.held.valid_res = predicted;
            wob.held.countdown = steps[5:0];
        end
        wob.extent_count = cnt[7:0];

        wob.seq = wob.seq + 4'd1;
        r = wob.held;
        r.sequence_res = wob.seq;
        return r;
    endfunction

    // one batch of four events near a target centroid, jittered, other bits random
    function automatic logic [IN_DATA_W-1:0] make_batch(input int x, input int y,
                                                        input int jitter);
        logic [IN_DATA_W-1:0] b;
        int ex;
        int ey;
        for (int i = 0; i < EVENTS_PER_BATCH; i++)
        begin
            ex = x + int'($urandom_range(2 * jitter)) - jitter;
            ey = y + int'($urandom_range(2 * jitter)) - jitter;
            ex = (ex < 0) ? 0 : (ex > 127) ? 127 : ex;
            ey = (ey < 0) ? 0 : (ey > 127) ? 127 : ey;
            b[32*i +: 32] = {1'($urandom), 7'(ex), 7'(ey), 17'($urandom)};
        end
        return b;
    endfunction

    function automatic cfg_t random_settings();
        cfg_t c;
        c.critical_amplitude    = 8'($urandom_range(40, 255));
        c.floor_amplitude       = 8'($urandom_range(0, 24));
        c.growth_windows_needed = 8'($urandom_range(0, 3));
        c.crossings_needed      = 8'($urandom_range(0, 4));
        c.countdown_limit       = 6'($urandom_range(1, 63));
        c.smoothing_shift       = 3'($urandom_range(0, 7));
        c.extent_window_batches = 8'($urandom_range(2, 16));
        c.period_window_batches = 8'($urandom_range(4, 32));
        // now and then a zero limit or a zero-length window
        if ($urandom_range(7) == 0)
            c.countdown_limit = '0;
        if ($urandom_range(9) == 0)
            c.extent_window_batches = '0;
        if ($urandom_range(9) == 0)
            c.period_window_batches = '0;
        return c;
    endfunction

    function automatic stim_row_t write_row(input cfg_idx_t idx, input logic [7:0] value);
        stim_row_t r;
        r.is_write = 1'b1;
        r.idx      = idx;
        r.value    = value;
        r.batch    = '0;
        r.typed    = 1'b0;
        r.want     = '0;
        return r;
    endfunction

    function automatic stim_row_t batch_row(input logic [IN_DATA_W-1:0] batch,
                                            input bit typed, input result_t want);
        stim_row_t r;
        r.is_write = 1'b0;
        r.idx      = REG_CRITICAL_AMPLITUDE;
        r.value    = '0;
        r.batch    = batch;
        r.typed    = typed;
        r.want     = want;
        return r;
    endfunction

    // mismatch line, printing capped so a broken block cannot flood the log
    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        if (mismatches < PRINT_CAP)
            $display("mismatch at status word %0d: %s got %0d want %0d",
                     results_checked, what, got, want);
        mismatches++;
    endtask

    // register write, only once every pending status word has come back
    task automatic set_register(input cfg_idx_t idx, input logic [7:0] value);
        s_tvalid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        apply_setting(idx, value);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_all(input cfg_t c);
        set_register(REG_CRITICAL_AMPLITUDE,    c.critical_amplitude);
        set_register(REG_FLOOR_AMPLITUDE,       c.floor_amplitude);
        set_register(REG_GROWTH_WINDOWS_NEEDED, c.growth_windows_needed);
        set_register(REG_CROSSINGS_NEEDED,      c.crossings_needed);
        set_register(REG_COUNTDOWN_LIMIT,       8'(c.countdown_limit));
        set_register(REG_SMOOTHING_SHIFT,       8'(c.smoothing_shift));
        set_register(REG_EXTENT_WINDOW_BATCHES, c.extent_window_batches);
        set_register(REG_PERIOD_WINDOW_BATCHES, c.period_window_batches);
    endtask

    // offer one batch word; on acceptance queue its expected status
    task automatic send_batch(input logic [IN_DATA_W-1:0] batch, input bit typed,
                              input result_t want);
        result_t guess;
        if (!steady)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= batch;
        do
            @(posedge clk);
        while (!s_tready);
        guess = predict_status(batch);
        pending_status.push_back(typed ? want : guess);
        batches_sent++;
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int holds_served;
        holds_served = 0;
        forever
        begin
            @(posedge clk);
            if (holds_served != holds_asked)
            begin
                m_tready <= 1'b0;
                for (int n = 1; n < HOLD_OFF_CYCLES; n++)
                    @(posedge clk);
                holds_served++;
            end
            else
                m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // status word check against the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_status.size() == 0)
                report_mismatch("status word with none pending", m_tdata, 0);
            else
            begin
                want = pending_status.pop_front();
                if (m_tdata[5:0] != want.countdown)
                    report_mismatch("countdown", m_tdata[5:0], want.countdown);
                if (m_tdata[13:6] != want.amplitude)
                    report_mismatch("amplitude", m_tdata[13:6], want.amplitude);
                if (m_tdata[20:14] != want.period)
                    report_mismatch("period", m_tdata[20:14], want.period);
                if (m_tdata[21] != want.valid_res)
                    report_mismatch("valid_res", m_tdata[21], want.valid_res);
                if (m_tdata[25:22] != want.sequence_res)
                    report_mismatch("sequence_res", m_tdata[25:22], want.sequence_res);
                if (m_tdata[31:26] != '0)
                    report_mismatch("zero fill", m_tdata[31:26], 0);
            end
            results_checked++;
        end
    end

    // run limit
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d words pending", cycles, pending_status.size());
        $display("end of test: mismatches");
        $finish;
    end

    // stimulus
    initial
    begin
        stim_row_t plan[$];
        int        spread[8];
        int        phase;
        int        random_sent;
        int        in_phase;
        int        seg_left;
        int        k;
        int        lvl;
        bit        noisy;
        bit        high_half;
        int        center_x;
        int        center_y;
        int        level0;
        int        rate;
        int        span;
        cfg_t      c;
        logic [IN_DATA_W-1:0] batch;

        spread = '{2, 6, 12, 20, 26, 32, 36, 40};
        settings = '{critical_amplitude:    RST_CRITICAL_AMPLITUDE,
                     floor_amplitude:       RST_FLOOR_AMPLITUDE,
                     growth_windows_needed: RST_GROWTH_WINDOWS_NEEDED,
                     crossings_needed:      RST_CROSSINGS_NEEDED,
                     countdown_limit:       RST_COUNTDOWN_LIMIT,
                     smoothing_shift:       RST_SMOOTHING_SHIFT,
                     extent_window_batches: RST_EXTENT_WINDOW_BATCHES,
                     period_window_batches: RST_PERIOD_WINDOW_BATCHES};
        wob = '{default: '0};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset values, extreme coordinates
        plan.push_back(batch_row('0, 1'b1, '{countdown: 6'd0, amplitude: 8'd0, period: 7'd0,
                                             valid_res: 1'b0, sequence_res: 4'd1}));
        plan.push_back(batch_row('1, 1'b1, '{countdown: 6'd0, amplitude: 8'd0, period: 7'd0,
                                             valid_res: 1'b0, sequence_res: 4'd2}));
        // zero-length windows close on every batch
        plan.push_back(write_row(REG_EXTENT_WINDOW_BATCHES, 8'd0));
        plan.push_back(write_row(REG_PERIOD_WINDOW_BATCHES, 8'd0));
        plan.push_back(write_row(REG_SMOOTHING_SHIFT, 8'd0));
        plan.push_back(batch_row(make_batch(0, 127, 0), 1'b0, '0));
        plan.push_back(batch_row(make_batch(127, 0, 0), 1'b0, '0));
        // growing swing around mid scale, permissive thresholds, zero countdown limit
        plan.push_back(write_row(REG_EXTENT_WINDOW_BATCHES, 8'd2));
        plan.push_back(write_row(REG_PERIOD_WINDOW_BATCHES, 8'd1));
        plan.push_back(write_row(REG_SMOOTHING_SHIFT, 8'd1));
        plan.push_back(write_row(REG_CROSSINGS_NEEDED, 8'd0));
        plan.push_back(write_row(REG_GROWTH_WINDOWS_NEEDED, 8'd0));
        plan.push_back(write_row(REG_FLOOR_AMPLITUDE, 8'd0));
        plan.push_back(write_row(REG_CRITICAL_AMPLITUDE, 8'd255));
        plan.push_back(write_row(REG_COUNTDOWN_LIMIT, 8'd0));
        foreach (spread[i])
        begin
            // real countdown, then the limit reached below the critical amplitude
            if (i == 4)
            begin
                plan.push_back(write_row(REG_COUNTDOWN_LIMIT, 8'd63));
                plan.push_back(write_row(REG_CRITICAL_AMPLITUDE, 8'd100));
            end
            if (i == 6)
                plan.push_back(write_row(REG_COUNTDOWN_LIMIT, 8'd1));
            plan.push_back(batch_row(make_batch(64 - spread[i], 40, 0), 1'b0, '0));
            plan.push_back(batch_row(make_batch(64 + spread[i], 40, 0), 1'b0, '0));
        end

        foreach (plan[i])
        begin
            if (plan[i].is_write)
                set_register(plan[i].idx, plan[i].value);
            else
                send_batch(plan[i].batch, plan[i].typed, plan[i].want);
        end

        // random phases: mostly wobble runs with random content, some noise
        phase = 0;
        random_sent = 0;
        seg_left = 0;
        noisy = 1'b0;
        while (random_sent < RANDOM_BATCHES)
        begin
            case (phase)
                0: c = '{critical_amplitude: 8'd255, floor_amplitude: 8'd255,
                         growth_windows_needed: 8'd255, crossings_needed: 8'd255,
                         countdown_limit: 6'd63, smoothing_shift: 3'd7,
                         extent_window_batches: 8'd255, period_window_batches: 8'd255};
                1: c = '{critical_amplitude: 8'd0, floor_amplitude: 8'd0,
                         growth_windows_needed: 8'd0, crossings_needed: 8'd0,
                         countdown_limit: 6'd1, smoothing_shift: 3'd0,
                         extent_window_batches: 8'd1, period_window_batches: 8'd1};
                default: c = random_settings();
            endcase
            write_all(c);
            if (phase == 2)
                holds_asked++;
            steady = (phase == 3);

            for (in_phase = 0; in_phase < PHASE_BATCHES && random_sent < RANDOM_BATCHES;
                 in_phase++)
            begin
                if (seg_left == 0)
                begin
                    noisy = ($urandom_range(1) == 0);
                    seg_left = noisy ? $urandom_range(5, 25) : $urandom_range(20, 100);
                    center_x = $urandom_range(20, 107);
                    center_y = $urandom_range(20, 107);
                    level0 = $urandom_range(0, 6);
                    rate = $urandom_range(1, 12);
                    span = $urandom_range(4, 34);
                    k = 0;
                end
                if (noisy)
                    batch = {$urandom, $urandom, $urandom, $urandom};
                else
                begin
                    // square swing whose size grows along the run
                    lvl = level0 + (k * rate) / 16;
                    high_half = (k % span) < (span / 2);
                    batch = make_batch(high_half ? center_x + lvl : center_x - lvl,
                                       high_half ? center_y + lvl / 2 : center_y - lvl / 2,
                                       1);
                end
                send_batch(batch, 1'b0, '0);
                k++;
                seg_left--;
                random_sent++;
            end
            phase++;
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;

        // drain
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d batches in %0d phases, %0d status words checked in %0d cycles",
                 batches_sent, phase, results_checked, cycles);
        $display("%0d extent windows closed, %0d with a topple prediction",
                 windows_closed, predictions);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
